@@ hw/rtl/optical_meter_pulse_detector_top_defines.svh @@
// Assertion macros used by the checker file.
`ifndef OPTICAL_METER_PULSE_DETECTOR_TOP_DEFINES_SVH
`define OPTICAL_METER_PULSE_DETECTOR_TOP_DEFINES_SVH

// Assert that an antecedent implies a consequent on the next edge.
`define OMPD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent on the same edge.
`define OMPD_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ompd_pkg.sv @@
// ----------------------------------------------------------------------------
// ompd_pkg
// Types and constants shared by the optical meter pulse detector.
// ----------------------------------------------------------------------------
package ompd_pkg;

    localparam int PROBES    = 32;
    localparam int BINS      = 1024;
    localparam int POS_W     = $clog2(PROBES);
    localparam int CNT_W     = $clog2(PROBES + 2);
    localparam int BIN_W     = $clog2(BINS);
    localparam int SAMPLE_W  = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] PH_PREWARM = 2'd0;
    localparam logic [1:0] PH_STABLE  = 2'd1;
    localparam logic [1:0] PH_UPHILL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROTATIONS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPHILL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd4;

    localparam logic [63:0] ENERGY_NUM = 64'd3600000000;

    typedef struct packed {
        logic [9:0]  sample;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  dominant;
        logic [1:0]  tracker_phase;
        logic        pulse;
        logic        watts_updated;
        logic [31:0] watts;
        logic [31:0] pulse_total;
    } out_item_t;

endpackage

@@ hw/rtl/optical_meter_pulse_detector_top.sv @@
// ----------------------------------------------------------------------------
// optical_meter_pulse_detector_top
// Sample window, histogram mode and curve tracker for an optical meter.
// ----------------------------------------------------------------------------
// Usage: one input transaction carries a sample and a millisecond time and
// yields exactly one output transaction. The block takes no new input
// transaction until the result of the previous one has been taken.
// An item passes through a histogram update (read and write of the old
// bin, then read and write of the new bin), a mode scan over all 1024 bins,
// a tracking step, on a pulse a serial divide, and an output step, then
// returns to idle. The histogram memory has one address for reads and writes.
// After reset a clearing pass sweeps all 1024 bins of the histogram,
// during which no input transaction is accepted; configuration writes are
// taken. The result stays in the output register while the receiver stalls.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// is to write it only while idle, as the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
module optical_meter_pulse_detector_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ompd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ompd_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import ompd_pkg::*;

    typedef enum logic [9:0]
    {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RDOLD = 10'b0000000100,
        S_WROLD = 10'b0000001000,
        S_RDNEW = 10'b0000010000,
        S_WRNEW = 10'b0000100000,
        S_SCAN  = 10'b0001000000,
        S_TRACK = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t st_reg;

    logic [5:0]          hist_mem [BINS];
    logic [5:0]          hist_rd_reg;
    logic [BIN_W-1:0]    hist_addr;
    logic                hist_we;
    logic [5:0]          hist_wd;

    logic [SAMPLE_W-1:0] ring_reg [PROBES];
    logic [POS_W-1:0]    wpos_reg;
    logic [CNT_W-1:0]    seen_reg;
    logic [1:0]          phase_reg;
    logic [7:0]          run_reg;
    logic [31:0]         pcount_reg;
    logic [31:0]         last_reg;
    logic [31:0]         power_reg;

    logic [15:0]         rot_reg, stab_reg, up_reg;
    logic [7:0]          need_reg;
    logic [31:0]         tmo_reg;

    logic [SAMPLE_W-1:0] samp_reg, old_reg;
    logic [31:0]         now_reg;
    logic [BIN_W:0]      scan_reg;
    logic [BIN_W-1:0]    best_reg;
    logic [5:0]          bestc_reg;
    logic                pulse_reg, upd_reg;
    logic                div_start;
    logic                div_done;
    logic [31:0]         div_q;
    logic [31:0]         interval;
    logic [25:0]         scaled;
    logic [25:0]         stab_prod, up_prod;
    logic                rd_valid_reg;

    assign interval  = now_reg - last_reg;
    assign scaled    = {8'd0, samp_reg, 8'd0};
    assign stab_prod = stab_reg * 26'(best_reg);
    assign up_prod   = up_reg * 26'(best_reg);

    always_comb
    begin
        hist_we   = 1'b0;
        hist_addr = '0;
        hist_wd   = '0;
        unique case (st_reg)
            S_CLEAR:
            begin
                hist_we   = 1'b1;
                hist_addr = scan_reg[BIN_W-1:0];
                hist_wd   = (scan_reg[BIN_W-1:0] == '0) ? 6'(PROBES) : '0;
            end
            S_RDOLD: hist_addr = old_reg;
            S_WROLD:
            begin
                hist_addr = old_reg;
                hist_we   = (hist_rd_reg != '0);
                hist_wd   = hist_rd_reg - 6'd1;
            end
            S_RDNEW: hist_addr = samp_reg;
            S_WRNEW:
            begin
                hist_addr = samp_reg;
                hist_we   = 1'b1;
                hist_wd   = hist_rd_reg + 6'd1;
            end
            S_SCAN:  hist_addr = scan_reg[BIN_W-1:0];
            default: hist_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_addr] <= hist_wd;
        end
        hist_rd_reg <= hist_mem[hist_addr];
    end

    assign div_start = (st_reg == S_TRACK) && (phase_reg == PH_UPHILL)
                       && (scaled > up_prod);

    ompd_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .rotations (rot_reg),
        .interval  (interval),
        .done      (div_done),
        .quotient  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_CLEAR;
            scan_reg     <= '0;
            wpos_reg     <= '0;
            seen_reg     <= '0;
            phase_reg    <= PH_PREWARM;
            run_reg      <= '0;
            pcount_reg   <= '0;
            last_reg     <= '0;
            power_reg    <= '0;
            rot_reg      <= 16'd1000;
            stab_reg     <= 16'd269;
            up_reg       <= 16'd282;
            need_reg     <= 8'd5;
            tmo_reg      <= 32'd60000;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < PROBES; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROTATIONS: rot_reg  <= cfg_data[15:0];
                    CFG_STABLE:    stab_reg <= cfg_data[15:0];
                    CFG_UPHILL:    up_reg   <= cfg_data[15:0];
                    CFG_NEEDED:    need_reg <= cfg_data[7:0];
                    CFG_TIMEOUT:   tmo_reg  <= cfg_data;
                    default:       ;
                endcase
            end
            unique case (st_reg)
                S_CLEAR:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg[BIN_W-1:0] == BIN_W'(BINS - 1))
                    begin
                        scan_reg <= '0;
                        st_reg   <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        samp_reg           <= in_data.sample;
                        now_reg            <= in_data.now_ms;
                        old_reg            <= ring_reg[wpos_reg];
                        ring_reg[wpos_reg] <= in_data.sample;
                        wpos_reg           <= wpos_reg + 1'b1;
                        if (seen_reg <= CNT_W'(PROBES))
                        begin
                            seen_reg <= seen_reg + 1'b1;
                        end
                        pulse_reg <= 1'b0;
                        upd_reg   <= 1'b0;
                        st_reg    <= S_RDOLD;
                    end
                end
                S_RDOLD: st_reg <= S_WROLD;
                S_WROLD: st_reg <= S_RDNEW;
                S_RDNEW: st_reg <= S_WRNEW;
                S_WRNEW:
                begin
                    scan_reg     <= '0;
                    best_reg     <= '0;
                    bestc_reg    <= '0;
                    rd_valid_reg <= 1'b0;
                    st_reg       <= S_SCAN;
                end
                S_SCAN:
                begin
                    rd_valid_reg <= 1'b1;
                    scan_reg     <= scan_reg + 1'b1;
                    if (rd_valid_reg && hist_rd_reg > bestc_reg)
                    begin
                        bestc_reg <= hist_rd_reg;
                        best_reg  <= BIN_W'(scan_reg - 1'b1);
                    end
                    if (scan_reg == (BIN_W + 1)'(BINS))
                    begin
                        st_reg <= S_TRACK;
                    end
                end
                S_TRACK:
                begin
                    st_reg <= S_OUT;
                    unique case (phase_reg)
                        PH_PREWARM:
                        begin
                            if (seen_reg > CNT_W'(PROBES))
                            begin
                                phase_reg <= PH_STABLE;
                            end
                        end
                        PH_STABLE:
                        begin
                            if (best_reg != '0 && scaled <= stab_prod)
                            begin
                                run_reg <= run_reg + 8'd1;
                                if (run_reg + 8'd1 >= need_reg)
                                begin
                                    phase_reg <= PH_UPHILL;
                                    run_reg   <= '0;
                                end
                            end
                        end
                        default:
                        begin
                            if (scaled > up_prod)
                            begin
                                phase_reg  <= PH_STABLE;
                                pulse_reg  <= 1'b1;
                                pcount_reg <= pcount_reg + 32'd1;
                                st_reg     <= S_DIV;
                            end
                        end
                    endcase
                    if (!div_start && (now_reg - last_reg) > tmo_reg)
                    begin
                        power_reg <= '0;
                        last_reg  <= now_reg;
                        upd_reg   <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        power_reg <= div_q;
                        last_reg  <= now_reg;
                        upd_reg   <= 1'b1;
                        st_reg    <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall                = (st_reg != S_IDLE);
    assign out_valid               = (st_reg == S_OUT);
    assign out_data.dominant       = best_reg;
    assign out_data.tracker_phase  = phase_reg;
    assign out_data.pulse          = pulse_reg;
    assign out_data.watts_updated  = upd_reg;
    assign out_data.watts          = power_reg;
    assign out_data.pulse_total    = pcount_reg;
endmodule

@@ hw/rtl/ompd_divider.sv @@
// ----------------------------------------------------------------------------
// ompd_divider
// Restoring divider for 3.6e9 / (rotations * interval), one bit per cycle.
// ----------------------------------------------------------------------------
module ompd_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] rotations,
    input  logic [31:0] interval,
    output logic        done,
    output logic [31:0] quotient
);
    import ompd_pkg::*;

    typedef enum logic [3:0]
    {
        D_IDLE = 4'b0001,
        D_MUL  = 4'b0010,
        D_RUN  = 4'b0100,
        D_DONE = 4'b1000
    } dstate_t;

    dstate_t     st_reg, st_next;
    logic [47:0] den_reg, den_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [5:0]  bit_reg, bit_next;
    logic [48:0] trial;

    assign trial = {rem_reg[47:0], ENERGY_NUM[bit_reg]};

    always_comb
    begin
        st_next  = st_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        bit_next = bit_reg;
        unique case (st_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    den_next = 48'(rotations) * 48'(interval);
                    st_next  = D_MUL;
                end
            end
            D_MUL:
            begin
                rem_next = '0;
                quo_next = '0;
                bit_next = 6'd31;
                if (den_reg == '0)
                begin
                    quo_next = '1;
                    st_next  = D_DONE;
                end
                else
                begin
                    st_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 64'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = 64'(trial);
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                bit_next = bit_reg - 6'd1;
                if (bit_reg == '0)
                begin
                    st_next = D_DONE;
                end
            end
            D_DONE:
            begin
                st_next = D_IDLE;
            end
            default:
            begin
                st_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= D_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
    end

    assign done     = (st_reg == D_DONE);
    assign quotient = quo_reg;
endmodule

@@ hw/rtl/ompd_checker.sv @@
// ----------------------------------------------------------------------------
// ompd_checker
// Port-level checks on the pulse detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "optical_meter_pulse_detector_top_defines.svh"

module ompd_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input ompd_pkg::out_item_t out_data
);
    import ompd_pkg::*;

    `OMPD_ASSERT_NOW(a_one_side, clk, rst_n, out_valid, in_stall, "input open with result pending")
    `OMPD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
    `OMPD_ASSERT_NOW(a_state, clk, rst_n, out_valid, out_data.tracker_phase != 2'd3, "bad curve state")
    `OMPD_ASSERT_NOW(a_pulse, clk, rst_n, out_valid && out_data.pulse, out_data.watts_updated && out_data.tracker_phase == PH_STABLE, "pulse without update")
endmodule

bind optical_meter_pulse_detector_top ompd_checker u_ompd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
